// ===== rtl/wslf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wslf_pkg;

   // Build-time defaults for the top level parameters.
   localparam int TAPS_DEFAULT        = 100;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int COEF_BITS_DEFAULT   = 16;

   // Filter design constants, Q30 fixed point.
   localparam longint FC_NUM      = 64'sd7;
   localparam longint FC_DEN      = 64'sd50;
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint WIN_A_Q30   = 64'sd579820585;
   localparam longint WIN_B_Q30   = 64'sd493921239;

   // Signed quotient truncated toward zero, shift-and-subtract. Elaboration only.
   function automatic longint div_trunc(input longint num, input longint den);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] quo;
      logic [64:0] rem;
      int          i;
      a   = (num < 0) ? -num : num;
      b   = (den < 0) ? -den : den;
      quo = '0;
      rem = '0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[63:0], a[i]};
         if (rem >= {1'b0, b}) begin
            rem    = rem - {1'b0, b};
            quo[i] = 1'b1;
         end
      end
      return ((num < 0) != (den < 0)) ? -$signed(quo) : $signed(quo);
   endfunction

   // Remainder with the sign of the dividend.
   function automatic longint mod_trunc(input longint num, input longint den);
      return num - den * div_trunc(num, den);
   endfunction

   // Taylor series sine, |x| <= pi/2, Q30 in and out.
   function automatic longint sin_small(input longint x);
      longint x2;
      longint term;
      longint sum;
      int     k;
      x2   = (x * x) / ONE_Q30;
      term = x;
      sum  = x;
      for (k = 1; k <= 9; k++) begin
         term = div_trunc(-((term * x2) / ONE_Q30), longint'((2 * k) * (2 * k + 1)));
         sum  = sum + term;
      end
      return sum;
   endfunction

   // Sine of an angle in [0, 2pi), folded into the first quarter wave.
   function automatic longint sin_folded(input longint a_raw);
      longint a;
      a = a_raw;
      if (a > PI_Q30) a = a - TWO_PI_Q30;
      if (a > HALF_PI_Q30) a = PI_Q30 - a;
      else if (a < -HALF_PI_Q30) a = -PI_Q30 - a;
      return sin_small(a);
   endfunction

   // One Hamming-windowed sinc tap before normalization, Q30. Elaboration only.
   function automatic longint tap_raw(input int taps, input int idx);
      longint n;
      longint m;
      longint base;
      longint cw;
      longint w;
      longint q;
      longint p;
      q = 4 * longint'(taps);
      n = longint'(idx) - longint'(taps / 2);
      if (n == 0) begin
         base = (TWO_PI_Q30 * FC_NUM) / FC_DEN;
      end else begin
         m    = ((FC_NUM * n) % FC_DEN + FC_DEN) % FC_DEN;
         base = div_trunc(sin_folded((TWO_PI_Q30 * (m % FC_DEN)) / FC_DEN), n);
      end
      p  = 4 * longint'(idx) + longint'(taps);
      cw = sin_folded(div_trunc(TWO_PI_Q30 * mod_trunc(p, q), q));
      w  = WIN_A_Q30 - (WIN_B_Q30 * cw) / ONE_Q30;
      return (base * w) / ONE_Q30;
   endfunction

   // Sum of all raw taps, the DC gain to normalize by.
   function automatic longint tap_sum(input int taps);
      longint sum;
      int     i;
      sum = 0;
      for (i = 0; i < taps; i++) sum = sum + tap_raw(taps, i);
      if (sum <= 0) sum = ONE_Q30;
      return sum;
   endfunction

   // One tap normalized to unity DC gain and rounded half away from zero
   // to Q1.(cbits-1). Elaboration only.
   function automatic longint coef_value(input int taps, input int cbits, input int idx,
                                         input longint sum);
      longint hsel;
      longint mag;
      longint c;
      longint cmax;
      longint cmin;
      hsel = tap_raw(taps, idx);
      cmax = (longint'(1) << (cbits - 1)) - 1;
      cmin = -(longint'(1) << (cbits - 1));
      mag  = (hsel < 0) ? -hsel : hsel;
      c    = div_trunc(2 * mag * (longint'(1) << (cbits - 1)) + sum, 2 * sum);
      if (hsel < 0) c = -c;
      if (c > cmax) c = cmax;
      if (c < cmin) c = cmin;
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/wslf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wslf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 100
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/windowed_sinc_lowpass_fir_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Windowed-sinc low-pass FIR, TAP_COUNT taps (Hamming window, cutoff 0.14 fs).
//
// req_ channel: one signed sample per transfer (req_sample_in).
// rsp_ channel: one filtered sample per input (rsp_filtered_out), rounded
//   to SAMPLE_BITS with saturation, plus rsp_settled, high once TAP_COUNT
//   samples have arrived, counting the current one.
// The sample history sits in a single-port-write, registered-read RAM used
// as a circular buffer; one shared multiplier walks the taps, one per cycle,
// through a read / multiply / accumulate pipeline.
// A new sample is taken only once the multiply-accumulate sweep over the
//   history RAM for the previous one has finished and its sum has been loaded
//   into the output register.
// req_ready is high while no sweep is running; a new sample is taken while
// the previous result still waits in the output register.
// If the receiver stalls, the finished sum waits until the output register
// frees up, and no further sample is taken meanwhile.
// Reset (synchronous, active high) empties the pipeline and the output and
// zeroes the history: RAM slots not yet written since reset read as zero,
// tracked by the fill count, so no clearing pass is needed.

module windowed_sinc_lowpass_fir_top
   import wslf_pkg::*;
#(
   parameter int TAP_COUNT   = TAPS_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int COEF_BITS   = COEF_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_filtered_out,
   output logic                               rsp_settled
);

   localparam int PTR_BITS  = $clog2(TAP_COUNT);
   localparam int CNT_BITS  = $clog2(TAP_COUNT + 1);
   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS  = PROD_BITS + CNT_BITS;

   localparam logic [PTR_BITS-1:0] TAP_LAST  = PTR_BITS'(TAP_COUNT - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL  = CNT_BITS'(TAP_COUNT);
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(2 ** (COEF_BITS - 2));
   localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic signed [ACC_BITS-1:0] SAT_LO = ACC_BITS'(-(2 ** (SAMPLE_BITS - 1)));

   // DC gain of the raw taps, for normalization
   localparam longint TAP_SUM = tap_sum(TAP_COUNT);

   // sweep sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   // Coefficient ROM, computed at elaboration.
   logic signed [COEF_BITS-1:0] coef_rom [TAP_COUNT];

   for (genvar g = 0; g < TAP_COUNT; g++) begin : g_coef
      localparam longint CoefVal = coef_value(TAP_COUNT, COEF_BITS, g, TAP_SUM);
      assign coef_rom[g] = CoefVal[COEF_BITS-1:0];
   end

   // control registers
   logic [1:0]          state_ff, state_in;
   logic [PTR_BITS-1:0] ptr_ff, ptr_in;       // slot for the next sample
   logic [CNT_BITS-1:0] seen_ff, seen_in;     // fill count, saturates
   logic [PTR_BITS-1:0] tap_ff, tap_in;
   logic [PTR_BITS-1:0] rd_idx_ff, rd_idx_in; // history slot for tap_ff
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_last_ff, s1_last_in;
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_last_ff, s2_last_in;
   logic                acc_done_ff, acc_done_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic                          s1_live_ff, s1_live_in;
   logic signed [COEF_BITS-1:0]   s1_coef_ff, s1_coef_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_settled_ff, rsp_settled_in;

   logic                          req_fire;
   logic                          rsp_load;
   logic [SAMPLE_BITS-1:0]        hist_rd_data;
   logic signed [ACC_BITS-1:0]    acc_rnd;
   logic signed [ACC_BITS-1:0]    acc_shift;
   logic signed [SAMPLE_BITS-1:0] y_sat;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_DRAIN) && acc_done_ff && (!rsp_valid_ff || rsp_ready);

   // History buffer: new sample written on the transfer, taps read during the sweep.
   wslf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (TAP_COUNT)
   ) u_hist (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (ptr_ff),
      .wr_data (req_sample_in),
      .rd_en   (state_ff == ST_RUN),
      .rd_addr (rd_idx_ff),
      .rd_data (hist_rd_data)
   );

   // round half up at the sample scale, then saturate
   always_comb begin
      acc_rnd   = acc_ff + ROUND_HALF;
      acc_shift = acc_rnd >>> (COEF_BITS - 1);
      if (acc_shift > SAT_HI) y_sat = SAT_HI[SAMPLE_BITS-1:0];
      else if (acc_shift < SAT_LO) y_sat = SAT_LO[SAMPLE_BITS-1:0];
      else y_sat = acc_shift[SAMPLE_BITS-1:0];
   end

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      seen_in        = seen_ff;
      tap_in         = tap_ff;
      rd_idx_in      = rd_idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_settled_in = rsp_settled_ff;

      // stage 1: RAM read in flight, coefficient fetched alongside
      s1_valid_in = (state_ff == ST_RUN);
      s1_last_in  = (tap_ff == TAP_LAST);
      s1_live_in  = (CNT_BITS'(rd_idx_ff) < seen_ff); // unwritten slots read as zero
      s1_coef_in  = coef_rom[tap_ff];

      // stage 2: product
      s2_valid_in = s1_valid_ff;
      s2_last_in  = s1_valid_ff && s1_last_ff;
      if (s1_live_ff) prod_in = s1_coef_ff * $signed(hist_rd_data);
      else prod_in = '0;

      // stage 3: accumulate
      acc_in      = acc_ff;
      acc_done_in = acc_done_ff;
      if (req_fire) begin
         acc_in      = '0;
         acc_done_in = 1'b0;
      end else if (s2_valid_ff) begin
         acc_in      = acc_ff + ACC_BITS'(prod_ff);
         acc_done_in = s2_last_ff;
      end

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in  = ST_RUN;
               tap_in    = '0;
               rd_idx_in = ptr_ff;
               ptr_in    = (ptr_ff == TAP_LAST) ? '0 : ptr_ff + 1'b1;
               if (seen_ff < CNT_FULL) seen_in = seen_ff + 1'b1;
            end
         end
         ST_RUN: begin
            tap_in    = tap_ff + 1'b1;
            rd_idx_in = (rd_idx_ff == '0) ? TAP_LAST : rd_idx_ff - 1'b1;
            if (tap_ff == TAP_LAST) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (rsp_load) begin
               state_in       = ST_IDLE;
               acc_done_in    = 1'b0;
               rsp_valid_in   = 1'b1;
               rsp_data_in    = y_sat;
               rsp_settled_in = (seen_ff == CNT_FULL);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         seen_ff      <= '0;
         tap_ff       <= '0;
         rd_idx_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_last_ff   <= 1'b0;
         acc_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         seen_ff      <= seen_in;
         tap_ff       <= tap_in;
         rd_idx_ff    <= rd_idx_in;
         s1_valid_ff  <= s1_valid_in;
         s1_last_ff   <= s1_last_in;
         s2_valid_ff  <= s2_valid_in;
         s2_last_ff   <= s2_last_in;
         acc_done_ff  <= acc_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_live_ff     <= s1_live_in;
      s1_coef_ff     <= s1_coef_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_settled_ff <= rsp_settled_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_out = rsp_data_ff;
   assign rsp_settled      = rsp_settled_ff;

   // fill count never passes the tap count
   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_FULL)
      else $error("fill count beyond tap count");

   // a new result only comes out of the drain state
   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DRAIN))
      else $error("result raised outside drain");

   // the last product of a sweep reaches the accumulator while draining
   a_last_in_drain: assert property (@(posedge clock) disable iff (reset)
      s2_last_ff |-> (state_ff == ST_DRAIN))
      else $error("last tap outside drain");

   // no sample is taken while a sweep is underway
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff || s2_valid_ff) |-> !req_fire)
      else $error("sample accepted during sweep");

endmodule

`default_nettype wire
